[sv/tdf_pkg.sv]
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared types and constants for the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

  // operand width of the value to factor
  localparam int WIDTH = 32;
  // trial divisor width: divisors stay below 2^(WIDTH/2) + 4
  localparam int DIV_W = WIDTH / 2 + 1;
  // bit counter of the shift-subtract divider
  localparam int CNT_W = $clog2(WIDTH);

  // word handed from the front to the back
  typedef struct packed {
    logic             trivial;  // value is 0 or 1, emitted as is
    logic [WIDTH-1:0] value;
  } tdf_item_t;

endpackage

[sv/tdf_front.sv]
// ----------------------------------------------------------------------------
// tdf_front
// Accepts input words, tags values 0 and 1, and buffers them in a
// two-entry queue toward the factoring engine.
// ----------------------------------------------------------------------------
module tdf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [tdf_pkg::WIDTH-1:0] in_tdata,   // [31:0] value
  output logic                      item_valid,
  input  logic                      item_ready,
  output tdf_pkg::tdf_item_t        item
);
  import tdf_pkg::*;

  tdf_item_t  q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  tdf_item_t  entry;

  assign in_tready  = (count_r != 2'd2);
  assign item_valid = (count_r != 2'd0);
  assign push       = in_tvalid && in_tready;
  assign pop        = item_valid && item_ready;

  always_comb begin
    entry.value   = in_tdata;
    entry.trivial = (in_tdata[WIDTH-1:1] == '0);
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= entry;
    end
  end

  assign item = q_mem[rd_ptr_r];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 && !pop) |=> (count_r == 2'd2 && $stable(wr_ptr_r)))
    else $error("queue written while full");
`endif

endmodule

[sv/tdf_back.sv]
// ----------------------------------------------------------------------------
// tdf_back
// Factoring engine: wheel-of-6 trial divisors, square bound check and a
// one-bit-per-cycle restoring divider; drives the registered result port.
// ----------------------------------------------------------------------------
module tdf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  tdf_pkg::tdf_item_t        item,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [tdf_pkg::WIDTH-1:0] out_tdata,  // [31:0] factor
  output logic                      out_tlast
);
  import tdf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic             step4_r, step4_nxt;
  logic [DIV_W-1:0] part_r, part_nxt;
  logic [WIDTH-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] out_factor_r, out_factor_nxt;
  logic             out_last_r, out_last_nxt;

  logic [2*DIV_W-1:0] sq;
  logic [DIV_W:0]     shifted;
  logic               ge;
  logic               out_free;
  logic               load;

  assign sq       = div_r * div_r;
  assign shifted  = {part_r, quot_r[WIDTH-1]};
  assign ge       = (shifted >= {1'b0, div_r});
  assign out_free = !out_valid_r || out_tready;

  assign item_ready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_factor_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    step4_nxt      = step4_r;
    part_nxt       = part_r;
    quot_nxt       = quot_r;
    cnt_nxt        = cnt_r;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    load           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          rem_nxt   = item.value;
          div_nxt   = DIV_W'(2);
          step4_nxt = 1'b0;
          state_nxt = item.trivial ? S_FINAL : S_CHECK;
        end
      end
      S_CHECK: begin
        // d*d > r is the same test as d > r/d
        if (sq > (2*DIV_W)'(rem_r)) begin
          state_nxt = S_FINAL;
        end else begin
          part_nxt  = '0;
          quot_nxt  = rem_r;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        part_nxt = ge ? DIV_W'(shifted - {1'b0, div_r}) : shifted[DIV_W-1:0];
        quot_nxt = {quot_r[WIDTH-2:0], ge};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (part_r == '0) begin
          // hit: emit divisor, keep it for a repeated factor
          if (out_free) begin
            load           = 1'b1;
            out_factor_nxt = WIDTH'(div_r);
            out_last_nxt   = 1'b0;
            rem_nxt        = quot_r;
            state_nxt      = S_CHECK;
          end
        end else begin
          if (div_r == DIV_W'(2)) begin
            div_nxt = DIV_W'(3);
          end else if (div_r == DIV_W'(3)) begin
            div_nxt   = DIV_W'(5);
            step4_nxt = 1'b0;
          end else begin
            div_nxt   = div_r + (step4_r ? DIV_W'(4) : DIV_W'(2));
            step4_nxt = !step4_r;
          end
          state_nxt = S_CHECK;
        end
      end
      S_FINAL: begin
        // leftover is prime (or the 0/1 input itself)
        if (out_free) begin
          load           = 1'b1;
          out_factor_nxt = rem_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      div_r       <= DIV_W'(2);
      step4_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      div_r       <= div_nxt;
      step4_r     <= step4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r       <= part_nxt;
    quot_r       <= quot_nxt;
    cnt_r        <= cnt_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_DONE) |-> (div_r >= DIV_W'(2)))
    else $error("trial divisor below two");
  a_part_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_DONE) |-> (part_r < div_r))
    else $error("partial remainder not below divisor");
  a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && sq > (2*DIV_W)'(rem_r)) |-> (rem_r > WIDTH'(1)))
    else $error("leftover value not above one");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_factor_r)))
    else $error("result register overwritten before taken");
`endif

endmodule

[sv/trial_division_factorizer_core.sv]
// The input queue registers each value; per trial divisor the engine then runs a
//   square check, a shift-subtract divide and a decide step; after a hit the same
//   divisor is checked again. The engine takes one value at a time, a new one only
//   once idle; worst case about 21845 wheel divisors are tried per 32-bit value.
// Input queue holds two values; results leave through one output register.
// Reset: synchronous, active low; clears queue and engine control, no clearing pass.
// ----------------------------------------------------------------------------
// trial_division_factorizer_core
// Prime factorizer by trial division over a wheel of 6, factors ascending.
// ----------------------------------------------------------------------------
module trial_division_factorizer_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [tdf_pkg::WIDTH-1:0] in_tdata,   // [31:0] value
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [tdf_pkg::WIDTH-1:0] out_tdata,  // [31:0] factor
  output logic                      out_tlast
);
  import tdf_pkg::*;

  logic      item_valid;
  logic      item_ready;
  tdf_item_t item;

  tdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  tdf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[verif/tdf_factor_checker.sv]
// ----------------------------------------------------------------------------
// tdf_factor_checker
// Watches both streams of the factorizer. Every accepted value is factored
// here by trial division over the 6-wheel. Each out word is compared with the
// oldest factor still owed. Mismatch count and owed count go to the top.
// ----------------------------------------------------------------------------
module tdf_factor_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [tdf_pkg::WIDTH-1:0] in_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [tdf_pkg::WIDTH-1:0] out_tdata,
  input  logic                      out_tlast,
  output int                        fail_count,
  output int                        owed_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdf_pkg::*;

  localparam int FACTOR_W    = 32;
  localparam int MAX_FACTORS = 32;

  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic                last;
  } factor_word_t;

  factor_word_t owed_q[$];
  int           mismatches = 0;

  // Queue the factors of one value, smallest first, last flagged.
  function automatic void queue_factors(input logic [WIDTH-1:0] value);
    longint unsigned rest;
    longint unsigned trial;
    longint unsigned found[$];
    bit              step_four;
    factor_word_t    w;
    rest      = value;
    trial     = 2;
    step_four = 1'b0;
    if (rest <= 1) begin
      found.push_back(rest);
    end else begin
      // past 31 factors whatever is left goes out as the final word
      while (trial <= rest / trial && found.size() < MAX_FACTORS - 1) begin
        if (rest % trial == 0) begin
          found.push_back(trial);
          rest = rest / trial;
        end else if (trial == 2) begin
          trial = 3;
        end else if (trial == 3) begin
          trial     = 5;
          step_four = 1'b0;
        end else begin
          trial     = trial + (step_four ? 4 : 2);
          step_four = !step_four;
        end
      end
      if (rest > 1) found.push_back(rest);
    end
    foreach (found[k]) begin
      w.factor = found[k][FACTOR_W-1:0];
      w.last   = (k == found.size() - 1);
      owed_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    factor_word_t w;
    if (rst_n) begin
      // retire before queueing so an early word never matches a new value
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got factor %0d last %0b",
                   $time, out_tdata[FACTOR_W-1:0], out_tlast);
          mismatches++;
        end else begin
          w = owed_q.pop_front();
          if (out_tdata[FACTOR_W-1:0] !== w.factor) begin
            $display("%0t: factor mismatch: expected %0d, got %0d",
                     $time, w.factor, out_tdata[FACTOR_W-1:0]);
            mismatches++;
          end
          if (out_tlast !== w.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, w.last, out_tlast);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) queue_factors(in_tdata);
      owed_count <= owed_q.size();
      fail_count <= mismatches;
    end
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the trial division factorizer: directed corner values, a
// back-pressure burst, then random values that are mostly products of small
// primes so the run stays short. Gives the verdict from the checker count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tdf_pkg::*;

  localparam int          CYCLE_LIMIT  = 5_000_000;
  localparam int          LONG_HOLD    = 3000;
  localparam int          TAIL_CYCLES  = 200;
  localparam int          RANDOM_ITEMS = 70;
  localparam int          BURST_ITEMS  = 10;
  localparam int          NUM_PRIMES   = 16;
  localparam logic [31:0] BIG_PRIME    = 32'd4294967291;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [WIDTH-1:0] in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [WIDTH-1:0] out_tdata;
  logic             out_tlast;

  int fail_count;
  int owed_count;
  int cycle_count = 0;
  bit tight;            // no idling on the sender side
  bit burst_on  = 1'b0; // asks the sink for its long hold
  bit sink_held = 1'b0;

  // 2 and 3 weighted up for long runs of repeated factors
  int unsigned small_primes[NUM_PRIMES] =
    '{2, 2, 2, 2, 3, 3, 5, 7, 11, 13, 17, 19, 23, 31, 61, 97};

  logic [31:0] corner_values[] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd25, 32'd35, 32'd49, 32'd121,
    32'd169, 32'd144, 32'd30030, 32'd63001, 32'd65521, 32'd65537, 32'd131074,
    32'h8000_0000, 32'd3486784401, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
    BIG_PRIME
  };

  trial_division_factorizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  tdf_factor_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[trial_division_factorizer_core] ERROR");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 150);
  endfunction

  // product of small primes, maybe times a cofactor below 4096: cheap to factor
  function automatic logic [31:0] smooth_value();
    longint unsigned v;
    longint unsigned p;
    int              n;
    v = 1;
    n = $urandom_range(1, 20);
    repeat (n) begin
      p = small_primes[$urandom_range(0, NUM_PRIMES - 1)];
      if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    if ($urandom_range(0, 2) != 0) begin
      p = $urandom_range(2, 4095);
      if (v * p <= 64'hFFFF_FFFF) v = v * p;
    end
    return v[31:0];
  endfunction

  task automatic offer(input logic [31:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = tight ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
  endtask

  // result sink: ready stretches, random holds, one long hold on request
  initial begin : sink
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (burst_on && !sink_held) begin
        sink_held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin : source
    int r;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    tight     = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) offer(corner_values[i]);

    // let everything out, then fill the input queue against a stalled sink
    wait_drained();
    tight    = 1'b1;
    burst_on <= 1'b1;
    repeat (BURST_ITEMS) offer(smooth_value());
    tight = 1'b0;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 25 == 0) tight = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 75)      offer(smooth_value());
      else if (r < 92) offer($urandom_range(0, 65535));
      else if (r < 97) offer($urandom_range(0, 1 << 20));
      else             offer($urandom_range(0, 1));
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[trial_division_factorizer_core] OK");
    end else begin
      $display("[trial_division_factorizer_core] ERROR");
    end
    $finish;
  end

endmodule
